### rtl/circular_queue_with_search_and_remove_defines.svh
// Assertion macros for the circular queue checker.
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_AND_REMOVE_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_AND_REMOVE_DEFINES_SVH

// same-cycle implication
`define CQSR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cqsr: check failed");

// next-cycle implication
`define CQSR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cqsr: check failed");

`endif

### rtl/cqsr_pkg.sv
`default_nettype none
package cqsr_pkg;

   localparam int DEPTH   = 16;
   localparam int DATA_W  = 64;
   localparam int IDX_W   = 4;
   localparam int COUNT_W = 5;

   localparam logic [2:0] MODE_PUSH  = 3'd0;
   localparam logic [2:0] MODE_POP   = 3'd1;
   localparam logic [2:0] MODE_GET   = 3'd2;
   localparam logic [2:0] MODE_FIND  = 3'd3;
   localparam logic [2:0] MODE_TAKE  = 3'd4;
   localparam logic [2:0] MODE_CLEAR = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]        mode;
      logic [DATA_W-1:0] data;
      logic [IDX_W-1:0]  index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [DATA_W-1:0]  data_out;
      logic [IDX_W-1:0]   position;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage
`default_nettype wire

### rtl/cqsr_cell.sv
`default_nettype none
module cqsr_cell (
   input  wire logic                       clock,
   input  wire cqsr_pkg::cell_ctrl_type    ctrl,
   input  wire logic [cqsr_pkg::DATA_W-1:0] next_data,
   input  wire logic [cqsr_pkg::DATA_W-1:0] push_data,
   input  wire logic [cqsr_pkg::DATA_W-1:0] key,
   output logic      [cqsr_pkg::DATA_W-1:0] data_out,
   output logic                             match_out
);

   logic [cqsr_pkg::DATA_W-1:0] data_ff, data_in;
   logic                        match_ff, match_in;

   always_comb begin
      if (ctrl.shift) begin
         data_in = next_data;
      end else if (ctrl.load) begin
         data_in = push_data;
      end else begin
         data_in = data_ff;
      end
      match_in = ctrl.valid && (data_ff == key);
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data_out  = data_ff;
   assign match_out = match_ff;

endmodule
`default_nettype wire

### rtl/circular_queue_with_search_and_remove.sv
// Queue of 16 words of 64 bits held oldest-first in a row of cells; a pop or
// take shifts the cells behind the removed entry one step toward the front.
// A request is taken when start is high and busy is low. Push, pop, get,
// take and clear answer in the cycle after the request; find answers once
// the cells have registered their compare results and a priority encoder
// has registered the oldest match; busy is high while it works. The result
// shows on rsp_item for the single cycle rsp_valid is high and cannot be held.
`default_nettype none
module circular_queue_with_search_and_remove (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire cqsr_pkg::req_type req_item,
   output logic                   rsp_valid,
   output cqsr_pkg::rsp_type      rsp_item
);

   logic [cqsr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         find_ff, find_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   cqsr_pkg::rsp_type            rsp_ff, rsp_in;

   logic [cqsr_pkg::DATA_W-1:0] cell_data [cqsr_pkg::DEPTH];
   logic [cqsr_pkg::DEPTH-1:0]  cell_match;
   cqsr_pkg::cell_ctrl_type     cell_ctrl [cqsr_pkg::DEPTH];

   logic                         accept, push_go, pop_go, take_go, idx_ok;
   logic [cqsr_pkg::COUNT_W-1:0] idx_ext;
   logic                         found;
   logic [cqsr_pkg::IDX_W-1:0]   found_pos;

   assign accept  = start && !find_ff;
   assign idx_ext = cqsr_pkg::COUNT_W'(req_item.index);
   assign idx_ok  = idx_ext < count_ff;
   assign push_go = accept && (req_item.mode == cqsr_pkg::MODE_PUSH)
                    && (count_ff != cqsr_pkg::COUNT_W'(cqsr_pkg::DEPTH));
   assign pop_go  = accept && (req_item.mode == cqsr_pkg::MODE_POP) && (count_ff != '0);
   assign take_go = accept && (req_item.mode == cqsr_pkg::MODE_TAKE) && idx_ok;

   for (genvar g = 0; g < cqsr_pkg::DEPTH; g++) begin : g_cell
      logic [cqsr_pkg::DATA_W-1:0] nxt;
      if (g == cqsr_pkg::DEPTH - 1) begin : g_last
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = cell_data[g+1];
      end

      always_comb begin
         cell_ctrl[g].valid = cqsr_pkg::COUNT_W'(g) < count_ff;
         cell_ctrl[g].shift = pop_go
                              || (take_go && (cqsr_pkg::COUNT_W'(g) >= idx_ext));
         cell_ctrl[g].load  = push_go && (count_ff == cqsr_pkg::COUNT_W'(g));
      end

      cqsr_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[g]),
         .next_data (nxt),
         .push_data (req_item.data),
         .key       (req_item.data),
         .data_out  (cell_data[g]),
         .match_out (cell_match[g])
      );
   end

   always_comb begin
      found     = 1'b0;
      found_pos = '0;
      for (int i = cqsr_pkg::DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            found     = 1'b1;
            found_pos = cqsr_pkg::IDX_W'(i);
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      find_in      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      if (find_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_in.status   = found ? cqsr_pkg::ST_OK : cqsr_pkg::ST_MISS;
         rsp_in.position = found_pos;
         rsp_in.count    = count_ff;
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         case (req_item.mode)
            cqsr_pkg::MODE_PUSH: begin
               if (push_go) begin
                  count_in = count_ff + cqsr_pkg::COUNT_W'(1);
               end else begin
                  rsp_in.status = cqsr_pkg::ST_FULL;
               end
            end
            cqsr_pkg::MODE_POP: begin
               if (pop_go) begin
                  count_in        = count_ff - cqsr_pkg::COUNT_W'(1);
                  rsp_in.data_out = cell_data[0];
               end else begin
                  rsp_in.status = cqsr_pkg::ST_MISS;
               end
            end
            cqsr_pkg::MODE_GET: begin
               if (idx_ok) begin
                  rsp_in.data_out = cell_data[req_item.index];
               end else begin
                  rsp_in.status = cqsr_pkg::ST_MISS;
               end
            end
            cqsr_pkg::MODE_FIND: begin
               rsp_valid_in = 1'b0;
               find_in      = 1'b1;
            end
            cqsr_pkg::MODE_TAKE: begin
               if (take_go) begin
                  count_in = count_ff - cqsr_pkg::COUNT_W'(1);
               end else begin
                  rsp_in.status = cqsr_pkg::ST_MISS;
               end
            end
            cqsr_pkg::MODE_CLEAR: begin
               count_in = '0;
            end
            default: begin
               rsp_in.status = cqsr_pkg::ST_MISS;
            end
         endcase
         rsp_in.count = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         find_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         find_ff      <= find_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = find_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

### rtl/cqsr_checker.sv
`default_nettype none
`include "circular_queue_with_search_and_remove_defines.svh"
module cqsr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire cqsr_pkg::req_type req_item,
   input wire logic              rsp_valid,
   input wire cqsr_pkg::rsp_type rsp_item
);

   `CQSR_ASSERT_NXT(a_quick_rsp, start && !busy && req_item.mode != cqsr_pkg::MODE_FIND, rsp_valid && !busy)
   `CQSR_ASSERT_NXT(a_find_busy, start && !busy && req_item.mode == cqsr_pkg::MODE_FIND, busy && !rsp_valid)
   `CQSR_ASSERT_NXT(a_find_rsp, busy, rsp_valid && !busy)
   `CQSR_ASSERT_IMP(a_full_count, rsp_valid && rsp_item.status == cqsr_pkg::ST_FULL, rsp_item.count == 5'(cqsr_pkg::DEPTH))
   `CQSR_ASSERT_IMP(a_count_max, rsp_valid, rsp_item.count <= 5'(cqsr_pkg::DEPTH))

endmodule

bind circular_queue_with_search_and_remove cqsr_checker u_cqsr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire
